// ===== hw/rtl/gns_pkg.sv =====
// Shared types, codes and constants for the grid neighbour smoothing block.
`timescale 1ns / 1ps
`default_nettype none
package gns_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_SWEEP = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam int SAMPLE_W = 16;
   localparam int COORD_W  = 6;
   localparam int FACTOR_W = 9;
   localparam int SUM_W    = 19;
   localparam int RECIP_W  = 19;
   localparam int RECIP_SH = 20;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam int BLEND_W  = FACTOR_W + 1 + SAMPLE_W;
   localparam logic [FACTOR_W-1:0] ONE_Q8 = 9'd256;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 9'd128;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_OUT,
      ST_SW_ISSUE,
      ST_SW_DRAIN,
      ST_SW_DIV,
      ST_SW_BLEND,
      ST_SW_WRITE,
      ST_SW_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic issue;
      logic div;
      logic blend;
      logic write_cell;
      logic out_read;
      logic out_done;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       last_tap;
      logic       last_cell;
      logic       out_free;
   } status_type;

   // Reciprocal of the neighbour count, scaled by 2**RECIP_SH and rounded up.
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] cnt);
      logic [RECIP_W-1:0] r;
      case (cnt)
         4'd3:    r = 19'd349526;
         4'd5:    r = 19'd209716;
         4'd8:    r = 19'd131072;
         default: r = 19'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/grid_neighbour_smoothing_core.sv =====
// Top level of the in-place 3x3 neighbour smoothing grid block.
//
// Requests arrive on req_*: req_tuser is the opcode (load, sweep, read),
// req_tdata carries column, row and the Q8.8 sample. Responses leave on
// rsp_*: rsp_tdata is the sample read (zero on sweep completion) and
// rsp_tuser is the kind (0 read data, 1 sweep finished). csr_* writes the
// 9-bit smoothing factor; write it only while the block is idle.
// A load gives no response. A read registers the sample from memory on
// acceptance, then moves it into the output register once that is free.
// A sweep visits every cell with nine tap steps that read the neighbours
// inside the grid and the cell itself, then a drain, a divide, a blend and
// a write step; after the last cell it loads the completion response
// into the output register once that register is free.
// A stalled receiver holds the pending response in the output register;
// loads are still taken while it waits, and a read or sweep is taken but
// holds the block in its output step until that register frees.
// Reset clears the control logic and sets the factor to 128; grid contents
// are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module grid_neighbour_smoothing_core #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // col[5:0], row[11:6], sample_in[27:12], zero pad
   input  wire  [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // sample_out[15:0]
   output logic        rsp_tuser,   // kind[0]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [15:0] csr_data     // smooth_factor[8:0], zero pad
);

   gns_pkg::cmd_type    cmd;
   gns_pkg::status_type status;

   assign csr_ready = 1'b1;

   gns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gns_dp #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/gns_ctrl.sv =====
// Sequencer for loads, reads and the in-place smoothing sweep.
`timescale 1ns / 1ps
`default_nettype none
module gns_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  gns_pkg::status_type  status,
   output gns_pkg::cmd_type     cmd
);

   gns_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gns_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gns_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (status.op == gns_pkg::OP_READ) begin
                  state_in = gns_pkg::ST_RD_OUT;
               end else if (status.op == gns_pkg::OP_SWEEP) begin
                  state_in = gns_pkg::ST_SW_ISSUE;
               end
            end
         end
         gns_pkg::ST_RD_OUT: begin
            if (status.out_free) state_in = gns_pkg::ST_IDLE;
         end
         gns_pkg::ST_SW_ISSUE: begin
            if (status.last_tap) state_in = gns_pkg::ST_SW_DRAIN;
         end
         gns_pkg::ST_SW_DRAIN: state_in = gns_pkg::ST_SW_DIV;
         gns_pkg::ST_SW_DIV:   state_in = gns_pkg::ST_SW_BLEND;
         gns_pkg::ST_SW_BLEND: state_in = gns_pkg::ST_SW_WRITE;
         gns_pkg::ST_SW_WRITE: begin
            state_in = status.last_cell ? gns_pkg::ST_SW_DONE : gns_pkg::ST_SW_ISSUE;
         end
         gns_pkg::ST_SW_DONE: begin
            if (status.out_free) state_in = gns_pkg::ST_IDLE;
         end
         default: state_in = gns_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready     = (state_ff == gns_pkg::ST_IDLE);
      cmd.accept     = (state_ff == gns_pkg::ST_IDLE) && req_tvalid;
      cmd.issue      = (state_ff == gns_pkg::ST_SW_ISSUE);
      cmd.div        = (state_ff == gns_pkg::ST_SW_DIV);
      cmd.blend      = (state_ff == gns_pkg::ST_SW_BLEND);
      cmd.write_cell = (state_ff == gns_pkg::ST_SW_WRITE);
      cmd.out_read   = (state_ff == gns_pkg::ST_RD_OUT) && status.out_free;
      cmd.out_done   = (state_ff == gns_pkg::ST_SW_DONE) && status.out_free;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/gns_dp.sv =====
// Grid memory, neighbour accumulation, division, blend and response register.
`timescale 1ns / 1ps
`default_nettype none
module gns_dp #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  [1:0]           req_tuser,
   input  wire  [31:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [15:0]          rsp_tdata,
   output logic                 rsp_tuser,
   input  wire                  csr_valid,
   input  wire  [15:0]          csr_data,
   input  gns_pkg::cmd_type     cmd,
   output gns_pkg::status_type  status
);

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int XW    = $clog2(GRID_WIDTH);
   localparam int YW    = $clog2(GRID_HEIGHT);

   logic [gns_pkg::SAMPLE_W-1:0] mem [CELLS];

   logic [gns_pkg::COORD_W-1:0]  col, row;
   logic [gns_pkg::SAMPLE_W-1:0] sample_in;
   logic                         in_grid;
   logic [AW-1:0]                req_addr, tap_addr, raddr;
   logic                         re, we;
   logic [AW-1:0]                waddr;
   logic [gns_pkg::SAMPLE_W-1:0] wdata;

   logic [gns_pkg::FACTOR_W-1:0] factor_ff;
   logic [gns_pkg::FACTOR_W-1:0] fsat, wold;
   logic [XW-1:0]                x_ff, nx;
   logic [YW-1:0]                y_ff, ny;
   logic [1:0]                   dx_ff, dy_ff;
   logic                         tap_ok, tap_center;
   logic                         tag_ff, center_ff, rd_ok_ff;
   logic [gns_pkg::SAMPLE_W-1:0] rdata_ff, old_ff;
   logic signed [gns_pkg::SUM_W-1:0] sum_ff;
   logic [gns_pkg::SUM_W-1:0]    mag;
   logic [3:0]                   cnt_ff;
   logic                         sign_ff;
   logic [gns_pkg::PROD_W-1:0]   prod_ff;
   logic [17:0]                  quot;
   logic [16:0]                  avg17;
   logic signed [gns_pkg::BLEND_W-1:0] pa_ff, pb_ff;
   logic signed [gns_pkg::BLEND_W:0]   total;
   logic                         rsp_valid_ff;
   logic [15:0]                  rsp_data_ff;
   logic                         rsp_kind_ff;

   assign col       = req_tdata[5:0];
   assign row       = req_tdata[11:6];
   assign sample_in = req_tdata[27:12];
   assign in_grid   = (int'(col) < GRID_WIDTH) && (int'(row) < GRID_HEIGHT);
   assign req_addr  = AW'(int'(col) * GRID_HEIGHT + int'(row));

   assign nx = x_ff + XW'(dx_ff) - XW'(1);
   assign ny = y_ff + YW'(dy_ff) - YW'(1);
   assign tap_ok = !(dx_ff == 2'd0 && x_ff == '0)
                && !(dx_ff == 2'd2 && x_ff == XW'(GRID_WIDTH - 1))
                && !(dy_ff == 2'd0 && y_ff == '0)
                && !(dy_ff == 2'd2 && y_ff == YW'(GRID_HEIGHT - 1));
   assign tap_center = (dx_ff == 2'd1) && (dy_ff == 2'd1);
   assign tap_addr = AW'(int'(nx) * GRID_HEIGHT + int'(ny));

   assign fsat = (factor_ff > gns_pkg::ONE_Q8) ? gns_pkg::ONE_Q8 : factor_ff;
   assign wold = gns_pkg::ONE_Q8 - fsat;
   assign mag  = sum_ff[gns_pkg::SUM_W-1] ? -sum_ff : sum_ff;
   assign quot = prod_ff[gns_pkg::PROD_W-1 -: 18];
   assign avg17 = sign_ff ? 17'(-quot) : 17'(quot);
   assign total = (gns_pkg::BLEND_W+1)'(pa_ff) + (gns_pkg::BLEND_W+1)'(pb_ff);

   always_comb begin
      re    = 1'b0;
      raddr = req_addr;
      we    = 1'b0;
      waddr = req_addr;
      wdata = sample_in;
      if (cmd.accept && req_tuser == gns_pkg::OP_READ) begin
         re = 1'b1;
      end
      if (cmd.accept && req_tuser == gns_pkg::OP_LOAD && in_grid) begin
         we = 1'b1;
      end
      if (cmd.issue) begin
         re    = tap_ok;
         raddr = tap_addr;
      end
      if (cmd.write_cell) begin
         we    = 1'b1;
         waddr = AW'(int'(x_ff) * GRID_HEIGHT + int'(y_ff));
         wdata = total[23:8];
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff    <= gns_pkg::FACTOR_RESET;
         tag_ff       <= 1'b0;
         center_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         dx_ff        <= '0;
         dy_ff        <= '0;
      end else begin
         if (csr_valid) factor_ff <= csr_data[gns_pkg::FACTOR_W-1:0];
         tag_ff    <= cmd.issue && tap_ok && !tap_center;
         center_ff <= cmd.issue && tap_center;
         if (cmd.accept) begin
            x_ff  <= '0;
            y_ff  <= '0;
            dx_ff <= '0;
            dy_ff <= '0;
         end
         if (cmd.issue) begin
            if (dy_ff == 2'd2) begin
               dy_ff <= '0;
               dx_ff <= (dx_ff == 2'd2) ? 2'd0 : dx_ff + 2'd1;
            end else begin
               dy_ff <= dy_ff + 2'd1;
            end
         end
         if (cmd.write_cell) begin
            if (y_ff == YW'(GRID_HEIGHT - 1)) begin
               y_ff <= '0;
               x_ff <= x_ff + XW'(1);
            end else begin
               y_ff <= y_ff + YW'(1);
            end
         end
         if (cmd.out_read || cmd.out_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) rd_ok_ff <= in_grid;
      if (cmd.issue && dx_ff == 2'd0 && dy_ff == 2'd0) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (tag_ff) begin
         sum_ff <= sum_ff + gns_pkg::SUM_W'($signed(rdata_ff));
         cnt_ff <= cnt_ff + 4'd1;
      end
      if (center_ff) old_ff <= rdata_ff;
      if (cmd.div) begin
         sign_ff <= sum_ff[gns_pkg::SUM_W-1];
         prod_ff <= gns_pkg::PROD_W'(mag) * gns_pkg::PROD_W'(gns_pkg::recip(cnt_ff));
      end
      if (cmd.blend) begin
         pa_ff <= $signed({1'b0, wold}) * $signed(old_ff);
         pb_ff <= $signed({1'b0, fsat}) * $signed(avg17[15:0]);
      end
      if (cmd.out_read) begin
         rsp_data_ff <= rd_ok_ff ? rdata_ff : '0;
         rsp_kind_ff <= gns_pkg::KIND_READ;
      end else if (cmd.out_done) begin
         rsp_data_ff <= '0;
         rsp_kind_ff <= gns_pkg::KIND_DONE;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   assign status.op        = req_tuser;
   assign status.last_tap  = (dx_ff == 2'd2) && (dy_ff == 2'd2);
   assign status.last_cell = (x_ff == XW'(GRID_WIDTH - 1)) && (y_ff == YW'(GRID_HEIGHT - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   a_cnt_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.div |-> (cnt_ff == 4'd3 || cnt_ff == 4'd5 || cnt_ff == 4'd8))
      else $error("neighbour count out of range");
   a_div_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.div |-> $past(cmd.issue, 2))
      else $error("division not preceded by tap reads");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_read && cmd.out_done))
      else $error("two responses loaded at once");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_read || cmd.out_done) |-> (!rsp_valid_ff || rsp_tready))
      else $error("response loaded over a pending one");

endmodule
`default_nettype wire
